// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator core.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned MAX_BLOCKS_DEF  = 64;
	localparam int unsigned HEADER_BYTES    = 17;
	localparam int unsigned MIN_SPLIT_BYTES = 16;
	localparam int unsigned LENGTH_CAP      = 4194304;
	localparam int unsigned OFFSET_W        = 22;
	localparam int unsigned SIZE_W          = 23;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_INIT  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_NO_MEMORY   = 3'd1,
		STAT_ZERO_SIZE   = 3'd2,
		STAT_DOUBLE_FREE = 3'd3,
		STAT_BAD_POINTER = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic {
		REG_HEAP_BASE   = 1'b0,
		REG_HEAP_LENGTH = 1'b1
	} reg_index_t;

	typedef struct packed {
		action_t              action;
		logic [SIZE_W-1:0]    request_bytes;
		logic [31:0]          payload_address;
	} command_t;

	typedef struct packed {
		logic [31:0]          result_address;
		logic [SIZE_W-1:0]    block_bytes;
		status_t              status;
		logic [SIZE_W-1:0]    bytes_allocated;
		logic [SIZE_W-1:0]    bytes_free;
	} result_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_A_WNEW,
		ST_A_WFOUND,
		ST_A_WNX,
		ST_F_MERGE,
		ST_F_PV,
		ST_F_WPV,
		ST_F_NX,
		ST_DONE
	} state_t;

	// saturating subtract of running byte counts
	function automatic logic [SIZE_W-1:0] sub_sat(input logic [SIZE_W-1:0] a,
			input logic [SIZE_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

// ===== rtl/first_fit_heap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator: descriptor list in a synchronous RAM, walked one
// descriptor per cycle; split on alloc, two-sided coalesce on free.
// ----------------------------------------------------------------------------
// Init and zero-size alloc go straight to ST_DONE; query, alloc and free walk
// the list to the match (N descriptors, at most MAX_BLOCKS), and free then
// merges the free successors and a free predecessor. The walk goes through the
// descriptor RAM read port; one command at a time.
// done pulses one cycle per command; the receiver cannot stall.
// Reset: the ST_INIT state writes the single free block, busy high meanwhile.
module first_fit_heap_allocator_core #(
	parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ffha_pkg::command_t         command,
	output logic                       done,
	output ffha_pkg::result_t          result,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [31:0]                cfg_data
);
	import ffha_pkg::*;

	localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned AW = $clog2(MAX_BLOCKS);
	localparam logic [IW-1:0] NO_SLOT = IW'(MAX_BLOCKS);
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_BLOCKS - 1);
	localparam logic [24:0] SPLIT_MARGIN = 25'(HEADER_BYTES + MIN_SPLIT_BYTES);

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [SIZE_W-1:0]   size;
		logic [IW-1:0]       next;
		logic [IW-1:0]       prev;
	} desc_t;

	// descriptor RAM
	desc_t desc_mem [MAX_BLOCKS];
	desc_t rdata_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	desc_t         wr_data;

	state_t state_q, state_d;
	command_t cmd_q;
	logic [31:0] base_q;
	logic [SIZE_W-1:0] length_q;
	logic [MAX_BLOCKS-1:0] free_q, spare_q;
	logic [SIZE_W-1:0] at_q, ft_q;
	logic [IW-1:0] cur_q, steps_q, s_q, bnext_q, final_q;
	logic [23:0] need_q;
	desc_t f_q, nxrec_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [31:0] res_addr_q;
	logic [SIZE_W-1:0] res_bytes_q;
	status_t res_status_q;
	logic done_q;
	result_t result_q;

	// lowest spare slot above slot zero
	function automatic logic [IW-1:0] first_spare(input logic [MAX_BLOCKS-1:0] m);
		logic [IW-1:0] r;
		r = NO_SLOT;
		for (int i = MAX_BLOCKS - 1; i >= 1; i--) begin
			if (m[i]) begin
				r = IW'(i);
			end
		end
		return r;
	endfunction

	// decoded conditions
	logic [SIZE_W-1:0] init_len, init_size;
	logic [23:0] need_c;
	logic cur_free, payload_hit, fit_hit, hit, walk_last, split_go, merge_free, pv_merge;
	logic [IW-1:0] spare_slot, pv;
	logic [SIZE_W-1:0] merged_b, merged_pv;

	assign init_len  = (length_q > SIZE_W'(LENGTH_CAP)) ? SIZE_W'(LENGTH_CAP) : length_q;
	assign init_size = (init_len > SIZE_W'(HEADER_BYTES)) ?
			(init_len - SIZE_W'(HEADER_BYTES)) : '0;
	assign need_c = (24'(command.request_bytes) + 24'd3) & ~24'd3;
	assign cur_free = free_q[cur_q[AW-1:0]];
	assign payload_hit = (base_q + 32'(rdata_q.offset) + 32'(HEADER_BYTES))
			== cmd_q.payload_address;
	assign fit_hit = cur_free && (24'(rdata_q.size) >= need_q);
	assign hit = (cmd_q.action == ACT_ALLOC) ? fit_hit : payload_hit;
	assign walk_last = (rdata_q.next >= NO_SLOT) || (steps_q == LAST_STEP);
	assign spare_slot = first_spare(spare_q);
	assign split_go = (25'(rdata_q.size) > (25'(need_q) + SPLIT_MARGIN))
			&& (spare_slot != NO_SLOT);
	assign merge_free = free_q[bnext_q[AW-1:0]];
	assign merged_b = bsize_q + SIZE_W'(HEADER_BYTES) + rdata_q.size;
	assign pv = f_q.prev;
	assign pv_merge = (pv < NO_SLOT) && free_q[pv[AW-1:0]];
	assign merged_pv = rdata_q.size + SIZE_W'(HEADER_BYTES) + bsize_q;

	// next state and RAM control
	always_comb begin
		state_d = state_q;
		rd_addr = cur_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = '{offset: '0, size: init_size, next: NO_SLOT, prev: NO_SLOT};
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				rd_addr = '0;
				if (start) begin
					if (command.action == ACT_INIT) begin
						wr_en   = 1'b1;
						wr_data = '{offset: '0, size: init_size, next: NO_SLOT,
								prev: NO_SLOT};
						state_d = ST_DONE;
					end else if (command.action == ACT_ALLOC &&
							command.request_bytes == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (hit) begin
					if (cmd_q.action == ACT_ALLOC) begin
						state_d = split_go ? ST_A_WNEW : ST_DONE;
					end else if (cmd_q.action == ACT_FREE && !cur_free) begin
						rd_addr = rdata_q.next[AW-1:0];
						state_d = (rdata_q.next < NO_SLOT) ? ST_F_MERGE : ST_F_PV;
					end else begin
						state_d = ST_DONE;
					end
				end else if (walk_last) begin
					state_d = ST_DONE;
				end else begin
					rd_addr = rdata_q.next[AW-1:0];
				end
			end
			ST_A_WNEW: begin
				wr_en   = 1'b1;
				wr_addr = s_q[AW-1:0];
				wr_data = '{offset: f_q.offset + OFFSET_W'(HEADER_BYTES) + OFFSET_W'(need_q),
						size: f_q.size - SIZE_W'(need_q) - SIZE_W'(HEADER_BYTES),
						next: f_q.next, prev: cur_q};
				state_d = ST_A_WFOUND;
			end
			ST_A_WFOUND: begin
				wr_en   = 1'b1;
				wr_addr = cur_q[AW-1:0];
				wr_data = '{offset: f_q.offset, size: SIZE_W'(need_q), next: s_q,
						prev: f_q.prev};
				rd_addr = f_q.next[AW-1:0];
				state_d = (f_q.next < NO_SLOT) ? ST_A_WNX : ST_DONE;
			end
			ST_A_WNX: begin
				wr_en   = 1'b1;
				wr_addr = f_q.next[AW-1:0];
				wr_data = rdata_q;
				wr_data.prev = s_q;
				state_d = ST_DONE;
			end
			ST_F_MERGE: begin
				if (merge_free && rdata_q.next < NO_SLOT) begin
					rd_addr = rdata_q.next[AW-1:0];
				end else begin
					state_d = ST_F_PV;
				end
			end
			ST_F_PV: begin
				rd_addr = pv[AW-1:0];
				if (pv_merge) begin
					state_d = ST_F_WPV;
				end else begin
					wr_en   = 1'b1;
					wr_addr = cur_q[AW-1:0];
					wr_data = '{offset: f_q.offset, size: bsize_q, next: bnext_q,
							prev: f_q.prev};
					state_d = ST_F_NX;
				end
			end
			ST_F_WPV: begin
				wr_en   = 1'b1;
				wr_addr = pv[AW-1:0];
				wr_data = '{offset: rdata_q.offset, size: merged_pv, next: bnext_q,
						prev: rdata_q.prev};
				state_d = ST_F_NX;
			end
			ST_F_NX: begin
				if (bnext_q < NO_SLOT) begin
					wr_en   = 1'b1;
					wr_addr = bnext_q[AW-1:0];
					wr_data = nxrec_q;
					wr_data.prev = final_q;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// descriptor RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			desc_mem[wr_addr] <= wr_data;
		end
		rdata_q <= desc_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			length_q <= SIZE_W'(LENGTH_CAP);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEAP_BASE:   base_q   <= cfg_data;
				REG_HEAP_LENGTH: length_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// slot maps and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '0;
			spare_q <= '0;
			at_q    <= '0;
			ft_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
			case (state_q)
				ST_INIT: begin
					free_q  <= MAX_BLOCKS'(1);
					spare_q <= ~MAX_BLOCKS'(1);
					at_q    <= '0;
					ft_q    <= init_size;
				end
				ST_IDLE: begin
					if (start && command.action == ACT_INIT) begin
						free_q  <= MAX_BLOCKS'(1);
						spare_q <= ~MAX_BLOCKS'(1);
						at_q    <= '0;
						ft_q    <= init_size;
					end
				end
				ST_WALK: begin
					if (hit && cmd_q.action == ACT_ALLOC) begin
						if (split_go) begin
							free_q[spare_slot[AW-1:0]]  <= 1'b1;
							spare_q[spare_slot[AW-1:0]] <= 1'b0;
						end else begin
							free_q[cur_q[AW-1:0]] <= 1'b0;
							ft_q <= sub_sat(ft_q, rdata_q.size);
							at_q <= at_q + rdata_q.size;
						end
					end else if (hit && cmd_q.action == ACT_FREE && !cur_free) begin
						free_q[cur_q[AW-1:0]] <= 1'b1;
						at_q <= sub_sat(at_q, rdata_q.size);
					end
				end
				ST_A_WFOUND: begin
					free_q[cur_q[AW-1:0]] <= 1'b0;
					ft_q <= sub_sat(ft_q, f_q.size)
							+ (f_q.size - SIZE_W'(need_q) - SIZE_W'(HEADER_BYTES));
					at_q <= at_q + SIZE_W'(need_q);
				end
				ST_F_MERGE: begin
					if (merge_free) begin
						ft_q <= sub_sat(ft_q, rdata_q.size);
						spare_q[bnext_q[AW-1:0]] <= 1'b1;
					end
				end
				ST_F_WPV: begin
					ft_q <= sub_sat(ft_q, rdata_q.size);
					free_q[cur_q[AW-1:0]]  <= 1'b0;
					spare_q[cur_q[AW-1:0]] <= 1'b1;
				end
				ST_F_NX: begin
					ft_q <= ft_q + bsize_q;
				end
				default: ;
			endcase
		end
	end

	// command datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q       <= command;
				need_q      <= need_c;
				cur_q       <= '0;
				steps_q     <= '0;
				res_addr_q  <= '0;
				res_bytes_q <= '0;
				res_status_q <= (command.action == ACT_ALLOC &&
						command.request_bytes == '0) ? STAT_ZERO_SIZE : STAT_OK;
			end
			ST_WALK: begin
				f_q     <= rdata_q;
				bsize_q <= rdata_q.size;
				bnext_q <= rdata_q.next;
				s_q     <= spare_slot;
				if (hit) begin
					unique case (cmd_q.action)
						ACT_ALLOC: begin
							res_addr_q  <= base_q + 32'(rdata_q.offset)
									+ 32'(HEADER_BYTES);
							res_bytes_q <= split_go ? SIZE_W'(need_q) : rdata_q.size;
						end
						ACT_FREE: begin
							if (cur_free) begin
								res_status_q <= STAT_DOUBLE_FREE;
							end
						end
						ACT_QUERY: begin
							if (cur_free) begin
								res_status_q <= STAT_BAD_POINTER;
							end else begin
								res_bytes_q <= rdata_q.size;
							end
						end
						default: ;
					endcase
				end else if (walk_last) begin
					if (cmd_q.action == ACT_ALLOC) begin
						res_status_q <= STAT_NO_MEMORY;
					end else if (cmd_q.payload_address != '0) begin
						res_status_q <= STAT_BAD_POINTER;
					end
				end else begin
					cur_q   <= rdata_q.next;
					steps_q <= steps_q + 1'b1;
				end
			end
			ST_F_MERGE: begin
				if (merge_free) begin
					bsize_q <= merged_b;
					bnext_q <= rdata_q.next;
				end else begin
					nxrec_q <= rdata_q;
				end
			end
			ST_F_PV: begin
				final_q <= cur_q;
			end
			ST_F_WPV: begin
				final_q <= pv;
				bsize_q <= merged_pv;
			end
			ST_DONE: begin
				result_q <= '{result_address: res_addr_q, block_bytes: res_bytes_q,
						status: res_status_q, bytes_allocated: at_q, bytes_free: ft_q};
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> !busy)
		else $error("result strobe while a command is in flight");
	a_slot0_kept: assert property (@(posedge clk) disable iff (!arst_n)
			state_q != ST_INIT |-> !spare_q[0])
		else $error("slot zero marked spare");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
			done |=> !done)
		else $error("two result strobes in a row");
`endif

endmodule
